FILE: rtl/pwpi_pkg.sv
// Shared constants for the particle wall-penalty integrator.
`default_nettype none
package pwpi_pkg;
	localparam int APB_AW = 6;
	localparam int APB_DW = 64;

	localparam logic [2:0] REG_MASS   = 3'd0;
	localparam logic [2:0] REG_DT     = 3'd1;
	localparam logic [2:0] REG_ALIM   = 3'd2;
	localparam logic [2:0] REG_KWALL  = 3'd3;
	localparam logic [2:0] REG_DWALL  = 3'd4;
	localparam logic [2:0] REG_WLOW   = 3'd5;
	localparam logic [2:0] REG_WHIGH  = 3'd6;
	localparam logic [2:0] REG_MARGIN = 3'd7;

	// acceleration scale factor: Q1.24, at most 1.0
	localparam int QFRAC = 24;
	localparam int QBITS = QFRAC + 1;

	localparam logic signed [63:0] GRAVITY_Q = -64'sd164584489;
endpackage
`default_nettype wire

FILE: rtl/pwpi_if.sv
// Particle and result channel interfaces.
`default_nettype none
interface pwpi_part_if #(parameter int W = 40);
	logic                valid;
	logic                ready;
	logic                is_fixed;
	logic signed [W-1:0] in_pos_x;
	logic signed [W-1:0] in_pos_y;
	logic signed [W-1:0] in_vel_x;
	logic signed [W-1:0] in_vel_y;
	logic signed [W-1:0] in_veval_x;
	logic signed [W-1:0] in_veval_y;
	logic signed [W-1:0] in_force_x;
	logic signed [W-1:0] in_force_y;
	modport source(output valid, is_fixed, in_pos_x, in_pos_y, in_vel_x, in_vel_y,
		in_veval_x, in_veval_y, in_force_x, in_force_y, input ready);
	modport sink(input valid, is_fixed, in_pos_x, in_pos_y, in_vel_x, in_vel_y,
		in_veval_x, in_veval_y, in_force_x, in_force_y, output ready);
endinterface

interface pwpi_res_if #(parameter int W = 40);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] out_pos_x;
	logic signed [W-1:0] out_pos_y;
	logic signed [W-1:0] out_vel_x;
	logic signed [W-1:0] out_vel_y;
	logic signed [W-1:0] out_veval_x;
	logic signed [W-1:0] out_veval_y;
	modport source(output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
		out_veval_x, out_veval_y, input ready);
	modport sink(input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
		out_veval_x, out_veval_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/pwpi_dly.sv
// Enabled delay line for payload that rides alongside the arithmetic.
`default_nettype none
module pwpi_dly #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];
endmodule
`default_nettype wire

FILE: rtl/pwpi_mul.sv
// 64x64 unsigned multiplier: registered 32x32 partials, then registered sum.
`default_nettype none
module pwpi_mul (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] p
);
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= a[31:0] * b[31:0];
			p01_s1 <= a[31:0] * b[63:32];
			p10_s1 <= a[63:32] * b[31:0];
			p11_s1 <= a[63:32] * b[63:32];
			p      <= {64'b0, p00_s1} + {32'b0, p01_s1, 32'b0}
				+ {32'b0, p10_s1, 32'b0} + {p11_s1, 64'b0};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/pwpi_mulq.sv
// Signed value times unsigned gain, round half away from zero, shift, saturate.
`default_nettype none
module pwpi_mulq #(
	parameter int W  = 40,
	parameter int SH = 32
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] a,
	input  logic [63:0]  g,
	output logic [W-1:0] y
);
	localparam logic [127:0] HALF = 128'd1 << (SH - 1);
	localparam logic [63:0]  MAXU = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - W);
	localparam logic [127:0] MAXP = {64'b0, MAXU};
	localparam logic [127:0] MINP = MAXP + 128'd1;

	logic [W-1:0]   mag;
	logic [127:0]   prod;
	logic [127:0]   rnd;
	logic [W-1:0]   y_nx;
	logic           neg_s1, neg_s2;

	assign mag = a[W-1] ? (~a + W'(1)) : a;

	pwpi_mul u_mul (
		.clk (clk),
		.en  (en),
		.a   (64'(mag)),
		.b   (g),
		.p   (prod)
	);

	always_comb begin
		rnd = (prod + HALF) >> SH;
		if (!neg_s2) begin
			y_nx = (rnd > MAXP) ? MAXU[W-1:0] : rnd[W-1:0];
		end else begin
			y_nx = (rnd > MINP) ? ~MAXU[W-1:0] : (~rnd[W-1:0] + W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[W-1];
			neg_s2 <= neg_s1;
			y      <= y_nx;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/pwpi_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module pwpi_sqrt #(
	parameter int W = 40
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] rad,
	output logic [W-1:0]   root
);
	logic [W+1:0]   rem_s  [W];
	logic [W-1:0]   root_s [W];
	logic [2*W-1:0] rad_s  [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W+1:0]   rem_i;
		logic [W-1:0]   root_i;
		logic [2*W-1:0] rad_i;
		logic [W+3:0]   rem_n;
		logic [W+3:0]   trial;
		logic [W+3:0]   diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
		end

		assign rem_n = {rem_i, rad_i[2*W-1 -: 2]};
		assign trial = {2'b00, root_i, 2'b01};
		assign diff  = rem_n - trial;
		assign ge    = (rem_n >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[W+1:0] : rem_n[W+1:0];
				root_s[k] <= {root_i[W-2:0], ge};
				rad_s[k]  <= rad_i << 2;
			end
		end
	end

	assign root = root_s[W-1];
endmodule
`default_nettype wire

FILE: rtl/pwpi_div.sv
// Pipelined restoring divider for the acceleration scale (limit * 2^24) / magnitude.
`default_nettype none
module pwpi_div
	import pwpi_pkg::*;
#(
	parameter int W = 40
) (
	input  logic             clk,
	input  logic             en,
	input  logic [38:0]      limit,
	input  logic [W-1:0]     den,
	output logic [QBITS-1:0] quo
);
	logic [W-1:0]     rem_s [QBITS];
	logic [QBITS-1:0] low_s [QBITS];
	logic [QBITS-1:0] quo_s [QBITS];
	logic [W-1:0]     den_s [QBITS];
	logic [63:0]      top64;

	assign top64 = {26'b0, limit[38:1]};

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		logic [W-1:0]     rem_i;
		logic [QBITS-1:0] low_i;
		logic [QBITS-1:0] quo_i;
		logic [W-1:0]     den_i;
		logic [W:0]       rem_n;
		logic [W:0]       diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_i = top64[W-1:0];
			assign low_i = {limit[0], {QFRAC{1'b0}}};
			assign quo_i = '0;
			assign den_i = den;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign low_i = low_s[k-1];
			assign quo_i = quo_s[k-1];
			assign den_i = den_s[k-1];
		end

		assign rem_n = {rem_i, low_i[QBITS-1]};
		assign diff  = rem_n - {1'b0, den_i};
		assign ge    = (rem_n >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[W-1:0] : rem_n[W-1:0];
				low_s[k] <= low_i << 1;
				quo_s[k] <= {quo_i[QBITS-2:0], ge};
				den_s[k] <= den_i;
			end
		end
	end

	assign quo = quo_s[QBITS-1];
endmodule
`default_nettype wire

FILE: rtl/particle_wall_penalty_integrate.sv
// Particle leapfrog integrator with acceleration limit and wall penalty springs.
//
//  channel    kind        dir  content
//  part_in    valid/ready in   static flag, position, velocity, evaluated velocity, force
//  part_out   valid/ready out  new position, velocity, evaluated velocity
//  apb        psel/pen.   in   8 config registers, 64-bit data, register i at 8*i
//
// One particle per cycle while the skid holds no beat.
// Depth is set by the square root (one root bit per stage) and the 25-stage divider.
// Reset clears valid bits and loads the register defaults.
// Output register plus skid beat; the pipe freezes only while the skid holds a beat.
`default_nettype none
module particle_wall_penalty_integrate
	import pwpi_pkg::*;
#(
	parameter int VALUE_WIDTH = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	pwpi_part_if.sink         part_in,
	pwpi_res_if.source        part_out
);
	localparam int W   = VALUE_WIDTH;
	localparam int LAT = 45 + W;
	localparam logic [63:0]  MAXU   = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - W);
	localparam logic [W-1:0] MAXW   = MAXU[W-1:0];
	localparam logic [W-1:0] MINW   = ~MAXU[W-1:0];
	localparam logic [W-1:0] GRAV_W = GRAVITY_Q[W-1:0];

	function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) sadd = s[W] ? MINW : MAXW;
		else sadd = s[W-1:0];
	endfunction

	function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) ssub = s[W] ? MINW : MAXW;
		else ssub = s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sneg(input logic [W-1:0] a);
		sneg = (a == MINW) ? MAXW : (~a + W'(1));
	endfunction

	function automatic logic [W-1:0] satw(input logic signed [63:0] v);
		if (v > $signed(MAXU)) satw = MAXW;
		else if (v < $signed(~MAXU)) satw = MINW;
		else satw = v[W-1:0];
	endfunction

	function automatic logic [W-1:0] absw(input logic [W-1:0] a);
		absw = a[W-1] ? (~a + W'(1)) : a;
	endfunction

	// ---------------- configuration ----------------
	logic [31:0] mass_q, dt_q;
	logic [38:0] alim_q, kw_q, kd_q, mgn_q;
	logic [39:0] wlo_q, whi_q;
	logic        apb_wr;

	assign apb_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= 32'd0;
			dt_q   <= 32'd2147484;
			alim_q <= 39'd3355443200;
			kw_q   <= 39'd201326592;
			kd_q   <= 39'd8589934592;
			wlo_q  <= -40'sd13421773;
			whi_q  <= 40'sd13421773;
			mgn_q  <= 39'd134218;
		end else if (apb_wr) begin
			unique case (paddr[5:3])
				REG_MASS:   mass_q <= pwdata[31:0];
				REG_DT:     dt_q   <= pwdata[31:0];
				REG_ALIM:   alim_q <= pwdata[38:0];
				REG_KWALL:  kw_q   <= pwdata[38:0];
				REG_DWALL:  kd_q   <= pwdata[38:0];
				REG_WLOW:   wlo_q  <= pwdata[39:0];
				REG_WHIGH:  whi_q  <= pwdata[39:0];
				REG_MARGIN: mgn_q  <= pwdata[38:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_MASS:   prdata = {32'b0, mass_q};
			REG_DT:     prdata = {32'b0, dt_q};
			REG_ALIM:   prdata = {25'b0, alim_q};
			REG_KWALL:  prdata = {25'b0, kw_q};
			REG_DWALL:  prdata = {25'b0, kd_q};
			REG_WLOW:   prdata = {{24{wlo_q[39]}}, wlo_q};
			REG_WHIGH:  prdata = {{24{whi_q[39]}}, whi_q};
			REG_MARGIN: prdata = {25'b0, mgn_q};
			default:    prdata = '0;
		endcase
	end

	logic [W-1:0] lo_w, hi_w, mg_w;
	assign lo_w = satw({{24{wlo_q[39]}}, wlo_q});
	assign hi_w = satw({{24{whi_q[39]}}, whi_q});
	assign mg_w = satw({25'b0, mgn_q});

	// ---------------- flow control ----------------
	logic           en;
	logic [LAT-2:0] vld_q;
	logic           skid_v_q, out_v_q;

	assign en            = !skid_v_q;
	assign part_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-3:0], part_in.valid};
		end
	end

	// ---------------- input fields ----------------
	logic [W-1:0] px, py, vx, vy, ex, ey, fx, fy;
	logic [W-1:0] pcx0, pcx, pcy;

	assign px = part_in.in_pos_x;
	assign py = part_in.in_pos_y;
	assign vx = part_in.in_vel_x;
	assign vy = part_in.in_vel_y;
	assign ex = part_in.in_veval_x;
	assign ey = part_in.in_veval_y;
	assign fx = part_in.in_force_x;
	assign fy = part_in.in_force_y;

	assign pcy  = ($signed(py) < $signed(lo_w)) ? lo_w : py;
	assign pcx0 = ($signed(px) < $signed(lo_w)) ? lo_w : px;
	assign pcx  = ($signed(pcx0) > $signed(hi_w)) ? hi_w : pcx0;

	// ---------------- wall penalties: left, right, bottom, top ----------------
	logic [W-1:0] dst_s1 [4];
	logic [W-1:0] vn_s1  [4];
	logic [W-1:0] pd_s2  [4];
	logic [W-1:0] vn_s2  [4];
	logic [W-1:0] mk     [4];
	logic [W-1:0] md     [4];
	logic [W-1:0] pen_s6 [4];
	logic [3:0]   trig, trig_d;
	logic [4*W-1:0] pen_d;

	always_ff @(posedge clk) begin
		if (en) begin
			dst_s1[0] <= ssub(px, lo_w);
			dst_s1[1] <= ssub(hi_w, px);
			dst_s1[2] <= ssub(py, lo_w);
			dst_s1[3] <= ssub(hi_w, py);
			vn_s1[0]  <= ex;
			vn_s1[1]  <= sneg(ex);
			vn_s1[2]  <= ey;
			vn_s1[3]  <= sneg(ey);
			for (int i = 0; i < 4; i++) begin
				pd_s2[i]  <= ssub(mg_w, dst_s1[i]);
				vn_s2[i]  <= vn_s1[i];
				pen_s6[i] <= trig_d[i] ? ssub(mk[i], md[i]) : '0;
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_wall
		assign trig[i] = !pd_s2[i][W-1] && (pd_s2[i] > W'(1));

		pwpi_mulq #(.W(W), .SH(QFRAC)) u_spring (
			.clk (clk), .en (en), .a (pd_s2[i]), .g ({25'b0, kw_q}), .y (mk[i])
		);
		pwpi_mulq #(.W(W), .SH(QFRAC)) u_damp (
			.clk (clk), .en (en), .a (vn_s2[i]), .g ({25'b0, kd_q}), .y (md[i])
		);
	end

	pwpi_dly #(.WIDTH(4), .DEPTH(3)) u_trig_dly (
		.clk (clk), .en (en), .d (trig), .q (trig_d)
	);

	pwpi_dly #(.WIDTH(4*W), .DEPTH(28 + W)) u_pen_dly (
		.clk (clk), .en (en),
		.d   ({pen_s6[3], pen_s6[2], pen_s6[1], pen_s6[0]}),
		.q   (pen_d)
	);

	// ---------------- acceleration and its limit ----------------
	logic [W-1:0]   ax0, ay0;
	logic [127:0]   sqx, sqy, l2;
	logic [127:0]   sum_s6, l2_s6;
	logic           over_s7, over_d;
	logic [W-1:0]   root;
	logic [QBITS-1:0] scl;
	logic [W-1:0]   ax_a, ay_a, ax_b, ay_b, scx, scy;

	pwpi_mulq #(.W(W), .SH(32)) u_fx (
		.clk (clk), .en (en), .a (fx), .g ({32'b0, mass_q}), .y (ax0)
	);
	pwpi_mulq #(.W(W), .SH(32)) u_fy (
		.clk (clk), .en (en), .a (fy), .g ({32'b0, mass_q}), .y (ay0)
	);

	pwpi_mul u_sqx (.clk (clk), .en (en), .a (64'(absw(ax0))), .b (64'(absw(ax0))), .p (sqx));
	pwpi_mul u_sqy (.clk (clk), .en (en), .a (64'(absw(ay0))), .b (64'(absw(ay0))), .p (sqy));
	pwpi_mul u_sql (.clk (clk), .en (en), .a ({25'b0, alim_q}), .b ({25'b0, alim_q}), .p (l2));

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6  <= sqx + sqy;
			l2_s6   <= l2;
			over_s7 <= (sum_s6 > l2_s6);
		end
	end

	pwpi_sqrt #(.W(W)) u_sqrt (
		.clk (clk), .en (en), .rad (sum_s6[2*W-1:0]), .root (root)
	);

	pwpi_div #(.W(W)) u_div (
		.clk (clk), .en (en), .limit (alim_q), .den (root), .quo (scl)
	);

	pwpi_dly #(.WIDTH(2*W), .DEPTH(28 + W)) u_acc_dly (
		.clk (clk), .en (en), .d ({ax0, ay0}), .q ({ax_a, ay_a})
	);
	pwpi_dly #(.WIDTH(2*W), .DEPTH(3)) u_acc_dly2 (
		.clk (clk), .en (en), .d ({ax_a, ay_a}), .q ({ax_b, ay_b})
	);
	pwpi_dly #(.WIDTH(1), .DEPTH(27 + W)) u_over_dly (
		.clk (clk), .en (en), .d (over_s7), .q (over_d)
	);

	pwpi_mulq #(.W(W), .SH(QFRAC)) u_scx (
		.clk (clk), .en (en), .a (ax_a), .g (64'(scl)), .y (scx)
	);
	pwpi_mulq #(.W(W), .SH(QFRAC)) u_scy (
		.clk (clk), .en (en), .a (ay_a), .g (64'(scl)), .y (scy)
	);

	// ---------------- gravity and walls, kept in model order ----------------
	logic [W-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic [W-1:0] penr_s1, penb_s1, pent_s1, pent_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= sadd(over_d ? scx : ax_b, pen_d[W-1:0]);
			ay_s1   <= sadd(over_d ? scy : ay_b, GRAV_W);
			penr_s1 <= pen_d[2*W-1:W];
			penb_s1 <= pen_d[3*W-1:2*W];
			pent_s1 <= pen_d[4*W-1:3*W];
			ax_s2   <= ssub(ax_s1, penr_s1);
			ay_s2   <= sadd(ay_s1, penb_s1);
			pent_s2 <= pent_s1;
			ax_s3   <= ax_s2;
			ay_s3   <= ssub(ay_s2, pent_s2);
		end
	end

	// ---------------- leapfrog step ----------------
	logic [W-1:0] mvx, mvy, mex, mey, vx_d, vy_d;
	logic [W-1:0] nvx_s1, nvy_s1, evx_s1, evy_s1;
	logic [W-1:0] nvx_d, nvy_d, evx_d, evy_d, dpx, dpy;

	pwpi_mulq #(.W(W), .SH(32)) u_mvx (
		.clk (clk), .en (en), .a (ax_s3), .g ({32'b0, dt_q}), .y (mvx)
	);
	pwpi_mulq #(.W(W), .SH(32)) u_mvy (
		.clk (clk), .en (en), .a (ay_s3), .g ({32'b0, dt_q}), .y (mvy)
	);
	pwpi_mulq #(.W(W), .SH(33)) u_mex (
		.clk (clk), .en (en), .a (ax_s3), .g ({32'b0, dt_q}), .y (mex)
	);
	pwpi_mulq #(.W(W), .SH(33)) u_mey (
		.clk (clk), .en (en), .a (ay_s3), .g ({32'b0, dt_q}), .y (mey)
	);

	pwpi_dly #(.WIDTH(2*W), .DEPTH(40 + W)) u_vel_dly (
		.clk (clk), .en (en), .d ({vx, vy}), .q ({vx_d, vy_d})
	);

	always_ff @(posedge clk) begin
		if (en) begin
			nvx_s1 <= sadd(vx_d, mvx);
			nvy_s1 <= sadd(vy_d, mvy);
			evx_s1 <= sadd(vx_d, mex);
			evy_s1 <= sadd(vy_d, mey);
		end
	end

	pwpi_mulq #(.W(W), .SH(32)) u_dpx (
		.clk (clk), .en (en), .a (nvx_s1), .g ({32'b0, dt_q}), .y (dpx)
	);
	pwpi_mulq #(.W(W), .SH(32)) u_dpy (
		.clk (clk), .en (en), .a (nvy_s1), .g ({32'b0, dt_q}), .y (dpy)
	);

	pwpi_dly #(.WIDTH(4*W), .DEPTH(3)) u_nv_dly (
		.clk (clk), .en (en),
		.d   ({nvx_s1, nvy_s1, evx_s1, evy_s1}),
		.q   ({nvx_d, nvy_d, evx_d, evy_d})
	);

	// original fields and clamped position ride to the final stage
	logic           fix_d;
	logic [W-1:0]   px_d, py_d, vxo_d, vyo_d, ex_d, ey_d, pcx_d, pcy_d;
	logic [6*W-1:0] fin;

	pwpi_dly #(.WIDTH(1 + 8*W), .DEPTH(44 + W)) u_item_dly (
		.clk (clk), .en (en),
		.d   ({part_in.is_fixed, px, py, vx, vy, ex, ey, pcx, pcy}),
		.q   ({fix_d, px_d, py_d, vxo_d, vyo_d, ex_d, ey_d, pcx_d, pcy_d})
	);

	assign fin = fix_d ? {px_d, py_d, vxo_d, vyo_d, ex_d, ey_d}
		: {sadd(pcx_d, dpx), sadd(pcy_d, dpy), nvx_d, nvy_d, evx_d, evy_d};

	// ---------------- output register and skid ----------------
	logic [6*W-1:0] out_q, skid_q;
	logic           pipe_v;

	assign pipe_v = vld_q[LAT-2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || part_out.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pipe_v;
			end
		end else if (pipe_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || part_out.ready) begin
			out_q <= skid_v_q ? skid_q : fin;
		end else if (pipe_v && en) begin
			skid_q <= fin;
		end
	end

	assign part_out.valid       = out_v_q;
	assign part_out.out_pos_x   = out_q[6*W-1:5*W];
	assign part_out.out_pos_y   = out_q[5*W-1:4*W];
	assign part_out.out_vel_x   = out_q[4*W-1:3*W];
	assign part_out.out_vel_y   = out_q[3*W-1:2*W];
	assign part_out.out_veval_x = out_q[2*W-1:W];
	assign part_out.out_veval_y = out_q[W-1:0];
endmodule
`default_nettype wire
